@@ design/lenient_utf8_to_utf16_decoder_defines.svh @@
// Assertion macros shared by the UTF-8 to UTF-16 decoder modules.
// Expects clk and rst_n in the scope of each use; compiles to nothing under SYNTH.
`ifndef LENIENT_UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define LENIENT_UTF8_TO_UTF16_DECODER_DEFINES_SVH

`ifndef SYNTH

// Check a property at every clock edge outside reset.
`define U8U16_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define U8U16_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define U8U16_ASSERT(label, prop, msg)

`define U8U16_NEVER(label, expr, msg)

`endif

`endif

@@ design/u8u16_pkg.sv @@
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// No dependencies; imported by every module of the block.
package u8u16_pkg;

  localparam int unsigned UNIT_W     = 16;
  localparam int unsigned MAX_UNITS  = 4;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Word index of the configuration registers (paddr[2]).
  localparam logic CFG_IDX_LOW_BYTE_MODE = 1'b0;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } u8u16_in_t;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              run_last;
    logic              text_done;
  } u8u16_out_t;

  // One queued transaction: up to four units, index of the last one, end of string.
  typedef struct packed {
    logic [MAX_UNITS-1:0][UNIT_W-1:0] units;
    logic [1:0]                       last_idx;
    logic                             eot;
  } u8u16_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } u8u16_qstat_t;

endpackage

@@ design/u8u16_front.sv @@
// Front end: accepts bytes, tracks the pending sequence and classifies each byte.
// Pushes the units a byte causes into the queue; depends on u8u16_pkg.
module u8u16_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  u8u16_pkg::u8u16_in_t    in_data,
  input  u8u16_pkg::u8u16_qstat_t q_stat,
  output logic                    q_push,
  output u8u16_pkg::u8u16_entry_t q_entry
);
  import u8u16_pkg::*;

  localparam logic [7:0]  ASCII_END    = 8'h80;
  localparam logic [7:0]  LEAD2_LO     = 8'hc2;
  localparam logic [7:0]  LEAD2_HI     = 8'hdf;
  localparam logic [7:0]  LEAD3_LO     = 8'he0;
  localparam logic [7:0]  LEAD3_HI     = 8'hef;
  localparam logic [7:0]  LEAD4_LO     = 8'hf0;
  localparam logic [7:0]  LEAD4_HI     = 8'hf4;
  localparam logic [7:0]  E0_MIN       = 8'ha0;
  localparam logic [7:0]  F0_MIN       = 8'h90;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [15:0] SURR_HI_BASE = 16'hd800;
  localparam logic [15:0] SURR_LO_BASE = 16'hdc00;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] n;
    if (b < ASCII_END) begin
      n = 3'd1;
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      n = 3'd2;
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      n = 3'd3;
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      n = 3'd4;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

  function automatic logic follow_ok(input logic [7:0] lead, input logic [1:0] k,
                                     input logic [7:0] c);
    logic ok;
    ok = (c[7:6] == 2'b10);
    if (k == 2'd1) begin
      if (lead == LEAD3_LO && c < E0_MIN) ok = 1'b0;
      if (lead == LEAD4_LO && c < F0_MIN) ok = 1'b0;
      if (lead == LEAD4_HI && c >= F0_MIN) ok = 1'b0;
    end
    return ok;
  endfunction

  logic [2:0][7:0] pend_r, pend_nxt;
  logic [1:0]      pcnt_r, pcnt_nxt;

  logic [3:0][7:0] seq;
  logic [7:0]      c;
  logic            eot;
  logic            in_fire;
  logic            emit;
  logic [2:0]      c_len, lead_len;
  logic            fol;
  logic [20:0]     cp, off;
  logic [15:0]     surr_hi, surr_lo;

  assign c        = in_data.text_byte;
  assign eot      = in_data.end_of_text;
  assign in_ready = !q_stat.full;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    // Held bytes first, then the new byte at the position after them.
    for (int i = 0; i < 3; i++) begin
      seq[i] = (2'(i) < pcnt_r) ? pend_r[i] : c;
    end
    seq[3]   = c;
    c_len    = seq_len(c);
    lead_len = seq_len(pend_r[0]);
    fol      = follow_ok(pend_r[0], pcnt_r, c);

    case (lead_len)
      3'd2:    cp = {10'd0, seq[0][4:0], seq[1][5:0]};
      3'd3:    cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
      default: cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
    endcase
    off     = cp - SUPP_BASE;
    surr_hi = SURR_HI_BASE + {6'd0, off[19:10]};
    surr_lo = SURR_LO_BASE + {6'd0, off[9:0]};
  end

  always_comb begin
    emit     = 1'b0;
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    for (int i = 0; i < MAX_UNITS; i++) begin
      q_entry.units[i] = {8'd0, seq[i]};
    end
    q_entry.last_idx = pcnt_r;
    q_entry.eot      = eot;

    if (pcnt_r == 2'd0) begin
      if (c_len > 3'd1 && !eot) begin
        pend_nxt[0] = c;
        pcnt_nxt    = 2'd1;
      end else begin
        emit = 1'b1;
      end
    end else if (fol) begin
      if ({1'b0, pcnt_r} + 3'd1 == lead_len) begin
        // Complete sequence: one BMP unit or a surrogate pair.
        emit     = 1'b1;
        pcnt_nxt = 2'd0;
        if (cp > {5'd0, 16'hffff}) begin
          q_entry.units[0] = surr_hi;
          q_entry.units[1] = surr_lo;
          q_entry.last_idx = 2'd1;
        end else begin
          q_entry.units[0] = cp[15:0];
          q_entry.last_idx = 2'd0;
        end
      end else if (eot) begin
        // Flush the cut-off sequence byte by byte.
        emit     = 1'b1;
        pcnt_nxt = 2'd0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) == pcnt_r) pend_nxt[i] = c;
        end
        pcnt_nxt = pcnt_r + 2'd1;
      end
    end else begin
      // Failed sequence: drop held bytes out as raw units, retry the new byte.
      emit = 1'b1;
      if (c_len > 3'd1 && !eot) begin
        q_entry.last_idx = pcnt_r - 2'd1;
        pend_nxt[0]      = c;
        pcnt_nxt         = 2'd1;
      end else begin
        pcnt_nxt = 2'd0;
      end
    end
  end

  assign q_push = in_fire && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= 2'd0;
    end else if (in_fire) begin
      pcnt_r <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_r <= pend_nxt;
    end
  end

`include "lenient_utf8_to_utf16_decoder_defines.svh"

  `U8U16_ASSERT(a_pending_is_prefix, (pcnt_r != 2'd0) |-> (seq_len(pend_r[0]) > {1'b0, pcnt_r}), "pending bytes do not form an open sequence")
  `U8U16_ASSERT(a_eot_clears_pending, (in_fire && eot) |=> (pcnt_r == 2'd0), "pending sequence survives end of text")

endmodule

@@ design/u8u16_queue.sv @@
// Short FIFO of decoded transactions between the front and back ends.
// Depends on u8u16_pkg for the entry and status types.
module u8u16_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  u8u16_pkg::u8u16_entry_t wr_entry,
  input  logic                    pop,
  output u8u16_pkg::u8u16_entry_t head,
  output u8u16_pkg::u8u16_qstat_t stat
);
  import u8u16_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u8u16_entry_t     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

`include "lenient_utf8_to_utf16_decoder_defines.svh"

  `U8U16_NEVER(a_no_push_full, push && stat.full, "push into a full queue")
  `U8U16_NEVER(a_no_pop_empty, pop && stat.empty, "pop from an empty queue")
  `U8U16_NEVER(a_cnt_in_range, cnt_r > CNT_W'(DEPTH), "queue fill beyond depth")

endmodule

@@ design/u8u16_back.sv @@
// Back end: walks the units of the queue head into the output register.
// Applies low byte mode and the run_last/text_done marks; depends on u8u16_pkg.
module u8u16_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    low_byte_mode,
  input  u8u16_pkg::u8u16_entry_t head,
  input  u8u16_pkg::u8u16_qstat_t q_stat,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output u8u16_pkg::u8u16_out_t   out_data
);
  import u8u16_pkg::*;

  logic         out_valid_r, out_valid_nxt;
  u8u16_out_t   out_data_r, out_data_nxt;
  logic [1:0]   idx_r, idx_nxt;
  logic         load;
  logic         is_last;
  logic [15:0]  unit;

  assign load    = !q_stat.empty && (!out_valid_r || out_ready);
  assign is_last = (idx_r == head.last_idx);
  assign pop     = load && is_last;

  always_comb begin
    unit = head.units[idx_r];
    if (low_byte_mode) unit = {8'd0, unit[7:0]};

    out_data_nxt.code_unit = unit;
    out_data_nxt.run_last  = is_last;
    out_data_nxt.text_done = is_last && head.eot;

    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/lenient_utf8_to_utf16_decoder.sv @@
// Lenient UTF-8 to UTF-16 decoder, top level.
// Input channel: one UTF-8 byte per transaction (in_valid/in_ready/in_data), with
//   end_of_text on the final byte of a string.
// Output channel: one UTF-16 code unit per transaction (out_valid/out_ready/out_data);
//   run_last marks the last unit caused by a byte, text_done the last unit of a string.
// A byte may cause no unit (held in an open sequence) or up to four units.
// Flow: with the queue empty, a byte's first unit passes through a queue entry and the
//   output register before it is presented. One byte is accepted per cycle while the
//   queue has room; the output register drains one unit per cycle while out_ready is
//   high, so multi-unit bytes fill the QUEUE_DEPTH-entry queue and hold input back.
// When the receiver stalls, the output register holds its unit, the queue fills and
//   in_ready drops; nothing is lost.
// Reset (synchronous, rst_n low) empties the queue, drops any open sequence and
//   clears low_byte_mode; no clearing pass is needed.
// Configuration: APB-style port, register low_byte_mode at byte address 0; write it
//   only while the block is idle.
module lenient_utf8_to_utf16_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  u8u16_pkg::u8u16_in_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output u8u16_pkg::u8u16_out_t                out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [u8u16_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [u8u16_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [u8u16_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready
);
  import u8u16_pkg::*;

  logic         low_byte_mode_r;
  logic         cfg_wr;
  logic         q_push, q_pop;
  u8u16_entry_t q_wr_entry, q_head;
  u8u16_qstat_t q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_byte_mode_r <= 1'b0;
    end else if (cfg_wr && paddr[2] == CFG_IDX_LOW_BYTE_MODE) begin
      low_byte_mode_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_IDX_LOW_BYTE_MODE) prdata[0] = low_byte_mode_r;
  end

  u8u16_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_entry  (q_wr_entry)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  u8u16_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .low_byte_mode (low_byte_mode_r),
    .head          (q_head),
    .q_stat        (q_stat),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

@@ tb/utf16_unit_checker.sv @@
// Scoreboard for the UTF-8 to UTF-16 decoder: watches both channels and the APB port.
// Predicts code units from accepted bytes and compares every accepted unit in order.
// Depends on u8u16_pkg for the payload types and the register index.
module utf16_unit_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  u8u16_pkg::u8u16_in_t             in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  u8u16_pkg::u8u16_out_t            out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [u8u16_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [u8u16_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                             pready,
  output int                               mismatches,
  output int                               outstanding
);
  import u8u16_pkg::*;

  logic [7:0] held_bytes[3];
  int         held_count;
  logic       low_byte_mode;
  u8u16_out_t expected_units[$];
  u8u16_out_t want;
  u8u16_out_t got;

  function automatic int utf8_seq_len(logic [7:0] b);
    if (b < 8'h80) return 1;
    if (b >= 8'hC2 && b <= 8'hDF) return 2;
    if (b >= 8'hE0 && b <= 8'hEF) return 3;
    if (b >= 8'hF0 && b <= 8'hF4) return 4;
    return 0;
  endfunction

  // Check byte c at position k after the lead.
  function automatic bit cont_ok(logic [7:0] lead, int k, logic [7:0] c);
    if (c[7:6] != 2'b10) return 1'b0;
    if (k == 1) begin
      if (lead == 8'hE0 && c < 8'hA0) return 1'b0;
      if (lead == 8'hF0 && c < 8'h90) return 1'b0;
      if (lead == 8'hF4 && c >= 8'h90) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic decode_utf8_byte(input logic [7:0] nb, input logic eot);
    logic [7:0]  seq[4];
    logic [15:0] units[$];
    logic [20:0] cp;
    u8u16_out_t  r;
    int          len;
    int          idx;
    int          need;
    int          avail;
    int          k;
    int          n;
    bit          ok;
    len = 0;
    idx = 0;
    for (k = 0; k < held_count; k++) begin
      seq[len] = held_bytes[k];
      len++;
    end
    seq[len] = nb;
    len++;
    held_count = 0;
    while (idx < len) begin
      need  = utf8_seq_len(seq[idx]);
      avail = len - idx;
      ok    = 1'b1;
      for (k = 1; k < need && k < avail; k++) begin
        if (ok && !cont_ok(seq[idx], k, seq[idx+k])) ok = 1'b0;
      end
      if (need <= 1 || !ok) begin
        // emit the lead on its own and retry from the next byte
        units.insert(units.size(), {8'h00, seq[idx]});
        idx++;
      end else if (avail >= need) begin
        case (need)
          2: cp = {10'd0, seq[idx][4:0], seq[idx+1][5:0]};
          3: cp = {5'd0, seq[idx][3:0], seq[idx+1][5:0], seq[idx+2][5:0]};
          default: cp = {seq[idx][2:0], seq[idx+1][5:0], seq[idx+2][5:0], seq[idx+3][5:0]};
        endcase
        if (cp <= 21'h00FFFF) begin
          units.insert(units.size(), cp[15:0]);
        end else begin
          cp = cp - 21'h010000;
          units.insert(units.size(), 16'hD800 + {6'd0, cp[19:10]});
          units.insert(units.size(), 16'hDC00 + {6'd0, cp[9:0]});
        end
        idx += need;
      end else if (eot) begin
        // flush a cut-off sequence byte by byte
        units.insert(units.size(), {8'h00, seq[idx]});
        idx++;
      end else begin
        // hold the valid prefix for the next transaction
        for (k = 0; k < avail; k++) held_bytes[k] = seq[idx+k];
        held_count = avail;
        idx = len;
      end
    end
    n = (units.size() > MAX_UNITS) ? MAX_UNITS : units.size();
    for (k = 0; k < n; k++) begin
      r.code_unit = low_byte_mode ? {8'h00, units[k][7:0]} : units[k];
      r.run_last  = (k == n - 1);
      r.text_done = eot && (k == n - 1);
      expected_units.insert(expected_units.size(), r);
    end
  endtask

  task automatic note_mismatch(input string field, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    mismatches++;
    $display("%0t %s: expected %h, got %h", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_bytes[0] = 8'h00;
      held_bytes[1] = 8'h00;
      held_bytes[2] = 8'h00;
      held_count    = 0;
      low_byte_mode = 1'b0;
      mismatches    = 0;
      expected_units.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_LOW_BYTE_MODE)
        low_byte_mode = pwdata[0];
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_units.size() == 0) begin
          mismatches++;
          $display("%0t code_unit: expected none, got %h", $time, got.code_unit);
        end else begin
          want = expected_units.pop_front();
          if (got.code_unit !== want.code_unit)
            note_mismatch("code_unit", want.code_unit, got.code_unit);
          if (got.run_last !== want.run_last)
            note_mismatch("run_last", want.run_last, got.run_last);
          if (got.text_done !== want.text_done)
            note_mismatch("text_done", want.text_done, got.text_done);
        end
      end
      if (in_valid && in_ready)
        decode_utf8_byte(in_data.text_byte, in_data.end_of_text);
    end
    outstanding = expected_units.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the decoder testbench: clock, reset, byte stimulus, APB writes and verdict.
// Depends on u8u16_pkg, lenient_utf8_to_utf16_decoder and utf16_unit_checker.
module tb_top;
  import u8u16_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 66;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  u8u16_in_t             in_data;
  logic                  out_valid;
  logic                  out_ready;
  u8u16_out_t            out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int         mismatch_count;
  int         pending_units;
  int         cycle_count;
  int         stall_left;
  int         rx_cycles;
  bit         rx_stalls;
  bit         tx_gaps;
  bit         calm;
  logic [7:0] text_bytes[$];

  // Bit 8 flags the end of the string.
  logic [8:0] directed_items[] = '{
    9'h000, 9'h07F, 9'h0FF, 9'h180,         // ASCII extremes, bad lead, lone continuation
    9'h0C2, 9'h080,                         // two-byte sequence
    9'h0E0, 9'h09F,                         // E0 with a low second byte fails early
    9'h0ED, 9'h0A0, 9'h180,                 // encoded surrogate passes through
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,         // highest code point, surrogate pair
    9'h0F4, 9'h090,                         // F4 with a high second byte
    9'h0F0, 9'h090, 9'h080, 9'h041,         // failed prefix yields four units at once
    9'h0E2, 9'h182                          // sequence cut off at end of text
  };

  lenient_utf8_to_utf16_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  utf16_unit_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatch_count),
    .outstanding (pending_units)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver back-pressure in bursts, enabled or disabled by rx_stalls.
  always @(posedge clk) begin
    if (rx_cycles % 50 == 0) rx_stalls = ($urandom_range(0, 2) != 0);
    rx_cycles++;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!calm && rx_stalls && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 13);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_mode(input logic mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CFG_IDX_LOW_BYTE_MODE, 2'b00};
    pwdata  <= {{(CFG_DATA_W-1){1'b0}}, mode};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Valid is left high after acceptance; the caller lowers it when the stream stops.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    if (!calm && tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_data.text_byte   <= b;
    in_data.end_of_text <= eot;
    in_valid            <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_units != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endtask

  task automatic push_cont();
    add_byte(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  // Append one character: mostly well-formed, otherwise noise or a broken sequence.
  task automatic append_char();
    logic [7:0] lead;
    case ($urandom_range(0, 9))
      6: add_byte(8'($urandom_range(0, 255)));
      7: begin
        add_byte(8'($urandom_range(8'hC2, 8'hF4)));
        add_byte(8'($urandom_range(0, 255)));
      end
      8: push_cont();
      9: begin
        lead = 8'($urandom_range(8'hF3, 8'hFF));
        add_byte((lead < 8'hF5) ? lead - 8'h33 : lead);  // C0, C1 or F5..FF
      end
      default: begin
        case ($urandom_range(1, 4))
          1: add_byte(8'($urandom_range(0, 8'h7F)));
          2: begin
            add_byte(8'($urandom_range(8'hC2, 8'hDF)));
            push_cont();
          end
          3: begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            add_byte(lead);
            if (lead == 8'hE0) add_byte(8'($urandom_range(8'hA0, 8'hBF)));
            else push_cont();
            push_cont();
          end
          default: begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
            add_byte(lead);
            if (lead == 8'hF0) add_byte(8'($urandom_range(8'h90, 8'hBF)));
            else if (lead == 8'hF4) add_byte(8'($urandom_range(8'h80, 8'h8F)));
            else push_cont();
            push_cont();
            push_cont();
          end
        endcase
      end
    endcase
  endtask

  initial begin
    int phase;
    int phase_items;
    int i;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_ready   <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    cycle_count = 0;
    stall_left  = 0;
    rx_cycles   = 0;
    calm        = 1'b0;
    tx_gaps     = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_mode(1'b0);
    foreach (directed_items[i]) send_byte(directed_items[i][7:0], directed_items[i][8]);
    in_valid <= 1'b0;
    wait_idle();

    for (phase = 0; phase < 3; phase++) begin
      write_mode((phase % 2 == 0) ? 1'b1 : 1'b0);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        text_bytes.delete();
        repeat ($urandom_range(1, 6)) append_char();
        // drop the tail now and then to cut a sequence off at end of text
        if (text_bytes.size() > 1 && $urandom_range(0, 4) == 0) void'(text_bytes.pop_back());
        tx_gaps = ($urandom_range(0, 2) != 0);
        if (phase == 2 && phase_items > PHASE_ITEMS / 2) calm = 1'b1;
        for (i = 0; i < text_bytes.size(); i++)
          send_byte(text_bytes[i], i == text_bytes.size() - 1);
        phase_items += text_bytes.size();
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/u8u16_pkg.sv
design/u8u16_front.sv
design/u8u16_queue.sv
design/u8u16_back.sv
design/lenient_utf8_to_utf16_decoder.sv
tb/utf16_unit_checker.sv
tb/tb_top.sv
